@@ src/rbg_pkg.sv @@
// ----------------------------------------------------------------------------
// rbg_pkg: shared types for the group-reversal block
// Word payload structs, chain control struct and controller states.
// ----------------------------------------------------------------------------
package rbg_pkg;

    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(1);

    typedef logic signed [31:0] t_word;

    typedef struct packed {
        t_word word_value;
        logic  stream_last;
    } t_in_word;

    typedef struct packed {
        t_word out_value;
        logic  run_last;
        logic  stream_done;
    } t_out_word;

    // shift_up moves every word one cell away from the head,
    // shift_down moves every word one cell toward the head
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } t_chain_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_REV,
        ST_FWD
    } t_state;

endpackage

@@ src/rbg_cell.sv @@
// ----------------------------------------------------------------------------
// rbg_cell: one storage cell of the word chain
// Holds one word and takes its neighbor's word on a shift in either direction.
// ----------------------------------------------------------------------------
module rbg_cell
    import rbg_pkg::*;
(
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  t_word      i_from_low,
    input  t_word      i_from_high,
    output t_word      o_word
);

    t_word r_word;
    t_word n_word;

    // pick the neighbor that moves in, else hold
    always_comb begin
        n_word = r_word;
        if (i_ctl.shift_up) begin
            n_word = i_from_low;
        end else if (i_ctl.shift_down) begin
            n_word = i_from_high;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

@@ src/rbg_ctrl.sv @@
// ----------------------------------------------------------------------------
// rbg_ctrl: sequencer for the group-reversal chain
// Counts held words, steers the chain and drives the output register.
// ----------------------------------------------------------------------------
module rbg_ctrl
    import rbg_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_word            i_head,
    input  t_word            i_tail,
    output t_chain_ctl       o_ctl
);

    localparam int KW = $clog2(MAX_GROUP + 1);

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_group_size;
    logic [KW-1:0]    r_held, n_held;
    logic [KW-1:0]    r_left, n_left;
    logic [KW-1:0]    r_align, n_align;
    logic             r_last, n_last;
    logic             r_out_valid, n_out_valid;
    t_out_word        r_out, n_out;

    logic [KW-1:0]    k_eff;
    logic [KW-1:0]    hold_next;
    logic             can_load;

    // clamp the group size into 1..MAX_GROUP
    always_comb begin
        if (r_group_size == '0) begin
            k_eff = KW'(1);
        end else if (r_group_size > MAX_GROUP) begin
            k_eff = KW'(MAX_GROUP);
        end else begin
            k_eff = KW'(r_group_size);
        end
    end

    assign hold_next = r_held + KW'(1);
    assign can_load  = !r_out_valid || !i_out_stall;

    // next state, chain control and output load
    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_left      = r_left;
        n_align     = r_align;
        n_last      = r_last;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_ctl       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.shift_up = 1'b1;
                    if (hold_next >= k_eff) begin
                        n_left  = hold_next;
                        n_held  = '0;
                        n_last  = i_in.stream_last;
                        n_state = ST_REV;
                    end else if (i_in.stream_last) begin
                        // short final group: slide oldest word to the tail first
                        n_left  = hold_next;
                        n_held  = '0;
                        n_last  = 1'b1;
                        n_align = KW'(MAX_GROUP) - hold_next;
                        n_state = ST_ALIGN;
                    end else begin
                        n_held = hold_next;
                    end
                end
            end
            ST_ALIGN: begin
                o_ctl.shift_up = 1'b1;
                n_align = r_align - KW'(1);
                if (r_align == KW'(1)) begin
                    n_state = ST_FWD;
                end
            end
            ST_REV: begin
                if (can_load) begin
                    o_ctl.shift_down  = 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.out_value   = i_head;
                    n_out.run_last    = (r_left == KW'(1));
                    n_out.stream_done = (r_left == KW'(1)) && r_last;
                    n_left            = r_left - KW'(1);
                    if (r_left == KW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FWD: begin
                if (can_load) begin
                    o_ctl.shift_up    = 1'b1;
                    n_out_valid       = 1'b1;
                    n_out.out_value   = i_tail;
                    n_out.run_last    = (r_left == KW'(1));
                    n_out.stream_done = (r_left == KW'(1)) && r_last;
                    n_left            = r_left - KW'(1);
                    if (r_left == KW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_group_size <= GROUP_SIZE_RESET;
            r_held       <= '0;
            r_left       <= '0;
            r_align      <= '0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_left      <= n_left;
            r_align     <= n_align;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_group_size <= i_cfg_data;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // count is cleared whenever a group is being drained
    a_held_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_held == '0))
        else $error("held count not cleared while draining");

    // a partial group never reaches the full depth
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held < KW'(MAX_GROUP)))
        else $error("held count reached buffer depth");

    // draining states always have words left
    a_left_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REV || r_state == ST_FWD) |-> (r_left != '0))
        else $error("drain with no words left");

    // last word of a group returns to idle
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_REV || r_state == ST_FWD) && can_load && r_left == KW'(1))
        |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle");

    // end of stream only on a group's final word
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stream_done) |-> r_out.run_last)
        else $error("stream_done without run_last");
`endif

endmodule

@@ src/block_reverse_groups_of_k.sv @@
// ----------------------------------------------------------------------------
// block_reverse_groups_of_k: reverse a word stream in groups of k
// Chain of word cells plus sequencer; emits full groups reversed and a
// short final group in arrival order.
// ----------------------------------------------------------------------------
// Words enter one per cycle while no group is complete. Each word shifts
// into the head of a MAX_GROUP-deep chain of cells. When k words are held
// (k = group_size clamped to 1..MAX_GROUP) the input stalls and the group
// drains from the head, newest first, one word per cycle while the output
// is not stalled. When the final word closes a short group of n words, the
// chain first slides toward its tail until the oldest word sits in the tail,
// then drains from the tail in arrival order. The output register stays
// full under downstream stall, which holds the drain. group_size may be
// written at any time the block has no group draining.
module block_reverse_groups_of_k
    import rbg_pkg::*;
#(
    parameter int MAX_GROUP = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_word         i_in,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_word        o_out,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_chain_ctl w_ctl;
    t_word      w_cell [MAX_GROUP];

    rbg_ctrl #(
        .MAX_GROUP (MAX_GROUP)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_cell[0]),
        .i_tail      (w_cell[MAX_GROUP-1]),
        .o_ctl       (w_ctl)
    );

    // build the chain; head takes the incoming word, tail holds on a down shift
    for (genvar g = 0; g < MAX_GROUP; g++) begin : g_cell
        t_word w_low;
        t_word w_high;
        if (g == 0) begin : g_head
            assign w_low = i_in.word_value;
        end else begin : g_mid_low
            assign w_low = w_cell[g-1];
        end
        if (g == MAX_GROUP - 1) begin : g_tail
            assign w_high = w_cell[g];
        end else begin : g_mid_high
            assign w_high = w_cell[g+1];
        end
        rbg_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_from_low  (w_low),
            .i_from_high (w_high),
            .o_word      (w_cell[g])
        );
    end

endmodule
